/* rtl/raised_cosine_speed_profile_assert.svh */
`ifndef RAISED_COSINE_SPEED_PROFILE_ASSERT_SVH
`define RAISED_COSINE_SPEED_PROFILE_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define RCSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcsp check failed");

// Checks that a condition implies a consequence in the next cycle.
`define RCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcsp check failed");

`endif

/* rtl/rcsp_pkg.sv */
package rcsp_pkg;

  localparam int COS_FRAC_BITS = 16;
  localparam int DATA_W = 32;
  localparam int COEF_W = 36;
  localparam int HORNER_STEPS = 6;
  localparam int PHASE_SHIFT = 30 - COS_FRAC_BITS;
  localparam int PIPE_DEPTH = COS_FRAC_BITS + 12;
  localparam int VDIV_W = 48;

  localparam logic signed [COEF_W-1:0] Q30_ONE = 36'sd1073741824;
  localparam logic signed [COEF_W-1:0] COEF_C6 = 36'sd2071865;

  typedef enum logic [1:0] {
    REG_TOTAL_TIME = 2'd0,
    REG_RAMP_TIME = 2'd1,
    REG_TRAVEL_DISTANCE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic inv;
    logic mid;
    logic down;
    logic flip;
  } ctl_t;

  // Coefficient subtracted at each Horner step, from C5 down to C1, then one.
  function automatic logic signed [COEF_W-1:0] horner_coef(input int step);
    logic signed [COEF_W-1:0] c;
    unique case (step)
      0: c = 36'sd27709939;
      1: c = 36'sd252684340;
      2: c = 36'sd1433727481;
      3: c = 36'sd4358008962;
      4: c = 36'sd5298703516;
      default: c = Q30_ONE;
    endcase
    return c;
  endfunction

endpackage

/* rtl/raised_cosine_speed_profile.sv */
// Raised-cosine speed profile. After any configuration write it computes the
// peak speed with a bit-serial 48-bit divider and holds in_ready low
// meanwhile. After that it accepts one query per cycle while the output is not
// stalled; the pipeline depth comes mostly from the one-bit-per-stage phase
// divider (COS_FRAC_BITS stages) and the six multiplier stages of the cosine
// polynomial. A stalled output freezes the whole pipeline.
module raised_cosine_speed_profile (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rcsp_pkg::DATA_W-1:0]        in_query_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rcsp_pkg::DATA_W-1:0] out_speed,
  output logic                               out_invalid,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [rcsp_pkg::DATA_W-1:0]        cfg_data
);
  import rcsp_pkg::*;

  localparam int F = COS_FRAC_BITS;
  localparam int ST_X = F + 1;
  localparam int ST_W = F + 9;
  localparam int ST_M = F + 10;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_DONE} vstate_t;

  logic [DATA_W-1:0] total_r, ramp_r;
  logic signed [DATA_W-1:0] dist_r, vmax_r;
  logic [DATA_W-1:0] flat_end;
  logic cfg_inv;
  vstate_t vst_r;
  logic [5:0] vcnt_r;
  logic [VDIV_W-1:0] vnum_r;
  logic [DATA_W-1:0] vrem_r;
  logic [DATA_W:0] vr;
  logic vge;
  logic [DATA_W:0] dmag;

  logic adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  ctl_t ctl_r [0:PIPE_DEPTH-1];
  ctl_t ctl_in;

  logic [DATA_W-1:0] dv_rem_r [0:F];
  logic [F-1:0] dv_quo_r [0:F];
  logic dv_sat_r [0:F];
  logic [DATA_W-1:0] tau;

  logic [F:0] qph;
  logic [30:0] xph;
  logic xflip;
  logic [29:0] xr_r;
  logic [59:0] xsq;

  logic signed [COEF_W-1:0] hp_r [0:HORNER_STEPS];
  logic [29:0] hy_r [0:HORNER_STEPS];

  logic signed [COEF_W-1:0] cval, cclamp;
  logic signed [COEF_W-1:0] wsum;
  logic signed [32:0] w_r;
  logic signed [64:0] mprod;
  logic signed [63:0] m_r, madj, mq;
  logic signed [DATA_W-1:0] speed_nxt;

  assign flat_end = total_r - ramp_r;
  assign cfg_inv = total_r <= ramp_r;
  assign cfg_ready = 1'b1;
  assign adv = !vld_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready = adv && (vst_r == S_IDLE);

  assign dmag = dist_r[DATA_W-1] ? -{dist_r[DATA_W-1], dist_r} : {dist_r[DATA_W-1], dist_r};
  assign vr = {vrem_r, vnum_r[VDIV_W-1]};
  assign vge = vr >= {1'b0, flat_end};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '1;
      ramp_r <= '1;
      dist_r <= 32'sh7FFFFFFF;
      vst_r <= S_IDLE;
      vcnt_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TOTAL_TIME: total_r <= cfg_data;
          REG_RAMP_TIME: ramp_r <= cfg_data;
          REG_TRAVEL_DISTANCE: dist_r <= cfg_data;
          default: ;
        endcase
        vst_r <= S_LOAD;
      end else begin
        unique case (vst_r)
          S_IDLE: ;
          S_LOAD: begin
            vnum_r <= {dmag[DATA_W-1:0], 16'b0};
            vrem_r <= '0;
            vcnt_r <= '0;
            vst_r <= S_RUN;
          end
          S_RUN: begin
            vrem_r <= vge ? 32'(vr - {1'b0, flat_end}) : vr[DATA_W-1:0];
            vnum_r <= {vnum_r[VDIV_W-2:0], vge};
            vcnt_r <= vcnt_r + 6'd1;
            if (vcnt_r == 6'(VDIV_W - 1)) begin
              vst_r <= S_DONE;
            end
          end
          S_DONE: begin
            if (dist_r[DATA_W-1]) begin
              vmax_r <= (vnum_r > 48'h80000000) ? 32'sh80000000 : 32'(48'd0 - vnum_r);
            end else begin
              vmax_r <= (vnum_r > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : vnum_r[DATA_W-1:0];
            end
            vst_r <= S_IDLE;
          end
          default: vst_r <= S_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid && in_ready};
    end
  end

  always_comb begin
    ctl_in.inv = cfg_inv || (ramp_r == '0 && in_query_time > total_r);
    ctl_in.down = !(in_query_time < ramp_r) && (in_query_time > flat_end);
    ctl_in.mid = !(in_query_time < ramp_r) && !(in_query_time > flat_end);
    ctl_in.flip = 1'b0;
    tau = (in_query_time < ramp_r) ? in_query_time : in_query_time - flat_end;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_in;
      dv_rem_r[0] <= tau;
      dv_quo_r[0] <= '0;
      dv_sat_r[0] <= tau >= ramp_r;
    end
  end

  for (genvar k = 1; k < PIPE_DEPTH; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (adv) begin
        if (k == ST_X) begin
          ctl_r[k] <= '{inv: ctl_r[k-1].inv, mid: ctl_r[k-1].mid,
                        down: ctl_r[k-1].down, flip: xflip};
        end else begin
          ctl_r[k] <= ctl_r[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [DATA_W:0] r;
    logic ge;
    assign r = {dv_rem_r[k], 1'b0};
    assign ge = r >= {1'b0, ramp_r};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k+1] <= ge ? 32'(r - {1'b0, ramp_r}) : r[DATA_W-1:0];
        dv_quo_r[k+1] <= {dv_quo_r[k][F-2:0], ge};
        dv_sat_r[k+1] <= dv_sat_r[k];
      end
    end
  end

  always_comb begin
    qph = dv_sat_r[F] ? (F+1)'(1 << F) : {1'b0, dv_quo_r[F]};
    xph = {qph, {PHASE_SHIFT{1'b0}}};
    xflip = qph > (F+1)'(1 << (F - 1));
    xsq = xr_r * xr_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xr_r <= xflip ? 30'(31'h40000000 - xph) : xph[29:0];
      hp_r[0] <= COEF_C6;
      hy_r[0] <= {2'b0, xsq[59:32]} << 2 | 30'(xsq[31:30]);
    end
  end

  for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
    logic signed [66:0] prod;
    logic signed [66:0] sh;
    assign prod = 67'(hp_r[h]) * 67'($signed({1'b0, hy_r[h]}));
    assign sh = prod >>> 30;
    always_ff @(posedge clk) begin
      if (adv) begin
        hp_r[h+1] <= horner_coef(h) - sh[COEF_W-1:0];
        hy_r[h+1] <= hy_r[h];
      end
    end
  end

  always_comb begin
    cval = ctl_r[ST_W-1].flip ? -hp_r[HORNER_STEPS] : hp_r[HORNER_STEPS];
    if (cval > Q30_ONE) begin
      cclamp = Q30_ONE;
    end else if (cval < -Q30_ONE) begin
      cclamp = -Q30_ONE;
    end else begin
      cclamp = cval;
    end
    wsum = ctl_r[ST_W-1].down ? Q30_ONE + cclamp : Q30_ONE - cclamp;
    mprod = 65'(vmax_r) * 65'(w_r);
    madj = m_r + (m_r[63] ? 64'sd2147483647 : 64'sd0);
    mq = madj >>> 31;
    if (ctl_r[ST_M].inv) begin
      speed_nxt = '0;
    end else if (ctl_r[ST_M].mid) begin
      speed_nxt = vmax_r;
    end else begin
      speed_nxt = mq[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r <= wsum[32:0];
      m_r <= mprod[63:0];
      out_speed <= speed_nxt;
      out_invalid <= ctl_r[ST_M].inv;
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];

  `include "raised_cosine_speed_profile_assert.svh"

  `RCSP_ASSERT_NOW(a_busy_blocks_input, clk, rst_n, vst_r != S_IDLE, !in_ready)
  `RCSP_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && out_invalid, out_speed == '0)
  `RCSP_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !adv, $stable(vld_r))

endmodule

/* bench/rcsp_speed_checker.sv */
module rcsp_speed_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [rcsp_pkg::DATA_W-1:0]        in_query_time,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [rcsp_pkg::DATA_W-1:0] out_speed,
  input  logic                               out_invalid,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [rcsp_pkg::DATA_W-1:0]        cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcsp_pkg::*;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam longint K1 = 64'sd5298703516;
  localparam longint K2 = 64'sd4358008962;
  localparam longint K3 = 64'sd1433727481;
  localparam longint K4 = 64'sd252684340;
  localparam longint K5 = 64'sd27709939;
  localparam longint K6 = 64'sd2071865;

  typedef struct {
    logic signed [31:0] speed;
    logic               invalid;
  } speed_beat_t;

  logic [31:0]        move_total;
  logic [31:0]        move_ramp;
  logic signed [31:0] move_dist;
  speed_beat_t        expected_speeds[$];

  assign pending = expected_speeds.size();

  function automatic longint cos_pi(longint x);
    logic   flip;
    longint xr;
    longint y;
    longint p;
    longint c;
    flip = x > HALF_Q30;
    xr = flip ? ONE_Q30 - x : x;
    y = (xr * xr) >>> 30;
    p = K6;
    p = K5 - ((p * y) >>> 30);
    p = K4 - ((p * y) >>> 30);
    p = K3 - ((p * y) >>> 30);
    p = K2 - ((p * y) >>> 30);
    p = K1 - ((p * y) >>> 30);
    c = ONE_Q30 - ((p * y) >>> 30);
    if (flip) c = -c;
    if (c > ONE_Q30) c = ONE_Q30;
    if (c < -ONE_Q30) c = -ONE_Q30;
    return c;
  endfunction

  function automatic longint ramp_phase(logic [31:0] tau);
    logic [63:0] q;
    q = {16'd0, tau, 16'd0} / {32'd0, move_ramp};
    if (q > 64'd65536) q = 64'd65536;
    return longint'(q << 14);
  endfunction

  function automatic speed_beat_t predict_speed(logic [31:0] t);
    speed_beat_t r;
    logic [31:0] flat_end;
    longint      vmax;
    longint      w;
    r.speed = '0;
    r.invalid = 1'b1;
    if (move_total <= move_ramp || (move_ramp == 0 && t > move_total)) return r;
    flat_end = move_total - move_ramp;
    vmax = (longint'(move_dist) * 64'sd65536) / longint'({32'd0, flat_end});
    if (vmax > 64'sd2147483647) vmax = 64'sd2147483647;
    if (vmax < -64'sd2147483648) vmax = -64'sd2147483648;
    if (t < move_ramp) begin
      w = ONE_Q30 - cos_pi(ramp_phase(t));
      vmax = (vmax * w) / 64'sd2147483648;
    end else if (t > flat_end) begin
      w = ONE_Q30 + cos_pi(ramp_phase(t - flat_end));
      vmax = (vmax * w) / 64'sd2147483648;
    end
    r.speed = vmax[31:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    speed_beat_t e;
    if (!rst_n) begin
      move_total <= 32'hFFFF_FFFF;
      move_ramp <= 32'hFFFF_FFFF;
      move_dist <= 32'sh7FFF_FFFF;
      expected_speeds.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOTAL_TIME: move_total <= cfg_data;
          REG_RAMP_TIME: move_ramp <= cfg_data;
          REG_TRAVEL_DISTANCE: move_dist <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_speeds.push_back(predict_speed(in_query_time));
      if (out_valid && out_ready) begin
        if (expected_speeds.size() == 0) begin
          $display("%0t: unexpected beat speed=%0d invalid=%0b", $realtime,
                   out_speed, out_invalid);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_speeds.pop_front();
          if (e.speed !== out_speed || e.invalid !== out_invalid) begin
            $display("%0t: expected speed=%0d invalid=%0b, got speed=%0d invalid=%0b",
                     $realtime, e.speed, e.invalid, out_speed, out_invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/tb_raised_cosine_speed_profile.sv */
module tb_raised_cosine_speed_profile;
  timeunit 1ns;
  timeprecision 1ps;
  import rcsp_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int TOTAL_ITEMS = 1400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_query_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_speed;
  logic               out_invalid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_TOTAL_TIME;
  logic [31:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  int                 sent = 0;
  int                 send_idle = 33;
  int                 recv_idle = 83;
  logic               stall_request = 1'b0;
  logic [31:0]        cur_total;
  logic [31:0]        cur_ramp;

  always #5 clk = ~clk;

  raised_cosine_speed_profile u_top (.*);

  rcsp_speed_checker u_checker (.*);

  initial begin
    int   stall_left;
    logic stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request && !stall_done) begin
        stall_left = 300;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_time(logic [31:0] t);
    if (sent < TOTAL_ITEMS / 3) begin
      send_idle = 33;
      recv_idle = 83;
    end else if (sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle = 83;
      recv_idle = 33;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_query_time <= t;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_profile(logic [31:0] total, logic [31:0] ramp, logic [31:0] distance);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    write_reg(REG_TOTAL_TIME, total);
    write_reg(REG_RAMP_TIME, ramp);
    write_reg(REG_TRAVEL_DISTANCE, distance);
    cur_total = total;
    cur_ramp = ramp;
  endtask

  function automatic logic [31:0] pick_time();
    logic [31:0] flat_end;
    logic [31:0] base;
    flat_end = cur_total - cur_ramp;
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(cur_total, 0);
      2: return $urandom_range(cur_ramp, 0);
      3: begin
        case ($urandom_range(3))
          0: base = cur_ramp;
          1: base = flat_end;
          2: base = cur_total;
          default: base = 32'd0;
        endcase
        return base + $urandom_range(4) - 2;
      end
      default: return flat_end + $urandom_range(cur_ramp, 0);
    endcase
  endfunction

  task automatic run_times(int n);
    repeat (n) send_time(pick_time());
  endtask

  initial begin
    logic [31:0] total;
    logic [31:0] ramp;
    logic [31:0] distance;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    cur_total = 32'hFFFF_FFFF;
    cur_ramp = 32'hFFFF_FFFF;
    send_time(32'd0);
    send_time(32'hFFFF_FFFF);

    set_profile(32'd100 << 16, 32'd20 << 16, 32'd50 << 16);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'd10 << 16);
    send_time((32'd20 << 16) - 1);
    send_time(32'd20 << 16);
    send_time(32'd80 << 16);
    send_time((32'd80 << 16) + 1);
    send_time(32'd90 << 16);
    send_time(32'd100 << 16);
    send_time((32'd100 << 16) + 1);
    send_time(32'hFFFF_FFFF);

    set_profile(32'd1000 << 16, 32'd0, 32'h8000_0000);
    send_time(32'd5);
    send_time(32'd1000 << 16);
    send_time((32'd1000 << 16) + 1);

    set_profile(32'd30 << 16, 32'd20 << 16, -(32'd7 << 16));
    send_time(32'd15 << 16);
    send_time(32'd25 << 16);

    set_profile(32'd2, 32'd1, 32'h7FFF_FFFF);
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'd2);

    for (int k = 0; k < 12; k++) begin
      distance = $urandom;
      if (k % 4 == 1) distance = 32'h8000_0000;
      if (k % 4 == 2) distance = 32'h7FFF_FFFF;
      case (k % 6)
        0: begin
          total = $urandom_range(32'hFFFF_FFFF, 1);
          ramp = $urandom_range(total - 1, 0);
        end
        1: begin
          total = $urandom_range(32'h00FF_FFFF, 2);
          ramp = $urandom_range(total - 1, 1);
        end
        2: begin
          total = $urandom;
          ramp = 32'd0;
        end
        3: begin
          total = 32'hFFFF_FFFF;
          ramp = (k < 6) ? 32'd0 : 32'hFFFF_FFFE;
        end
        4: begin
          ramp = $urandom;
          total = $urandom_range(ramp, 0);
        end
        default: begin
          total = $urandom_range(32'hFFFF_FFFF, 1);
          ramp = total - 1;
        end
      endcase
      set_profile(total, ramp, distance);
      if (k == 1) begin
        run_times(20);
        stall_request = 1'b1;
        run_times(90);
      end else begin
        run_times(110);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
